FILE: design/bli_pkg.sv
package bli_pkg;

   // Word formats: signed Q16.16 state, unsigned Q16.16 mass, unsigned Q15.16 time step
   localparam int WORD_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int MASS_W    = 32;
   localparam int DT_W      = 31;
   localparam int CMD_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int KE_W      = 48;

   // Derived datapath widths
   localparam int MAG_W     = WORD_W + 1;          // step magnitude, up to 2^WORD_W
   localparam int SUM_W     = WORD_W + 3;          // signed base plus or minus a step
   localparam int PROD_W    = 2 * WORD_W;          // shared multiplier product
   localparam int NUM_W     = WORD_W + DT_W;       // force times time step
   localparam int DEN_W     = MASS_W + 1;          // mass, doubled for half steps
   localparam int QUO_W     = WORD_W + 2;          // quotient bits kept by the divider
   localparam int DIV_STEPS = QUO_W / 2;           // two quotient bits per cycle
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int ACC_W     = PROD_W + MASS_W;     // speed squared times mass
   localparam int KE_SHIFT  = 2 * FRAC_W + 1;      // back to Q16.16 and times one half

   localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);  // 1.0
   localparam logic [DT_W-1:0]   DT_RESET   = DT_W'(655);      // about 0.01

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_FORCE = 3'd0,
      CMD_CLR_FORCE = 3'd1,
      CMD_EULER     = 3'd2,
      CMD_PRE_HALF  = 3'd3,
      CMD_POST_HALF = 3'd4,
      CMD_LOAD_POS  = 3'd5,
      CMD_LOAD_VEL  = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BODY_MASS = 1'b0,
      CSR_TIME_STEP = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRC_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_VEL_UPD,
      ST_VEL_MUL,
      ST_POS_UPD,
      ST_KE_SQX,
      ST_KE_SQY,
      ST_KE_SUM,
      ST_KE_MLO,
      ST_KE_MHI,
      ST_KE_ACC,
      ST_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      MS_FRC_DT,
      MS_VEL_DT,
      MS_VEL_SQX,
      MS_VEL_SQY,
      MS_SQ_LO,
      MS_SQ_HI
   } mul_sel_type;

   typedef struct packed {
      logic        idle;
      mul_sel_type mul_sel;
      logic        div_start;
      logic        vel_upd;
      logic        pos_upd;
      logic        comp;
      logic        half;
      logic        sq_load;
      logic        sq_add;
      logic        ke_load;
      logic        ke_add;
      logic        rsp_load;
   } ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic                     clip;
      logic signed [WORD_W-1:0] value;
   } sat_type;

endpackage

FILE: design/bli_div.sv
module bli_div import bli_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_stat_type       stat,
   output logic [QUO_W-1:0]   quo,
   output logic               ovf
);

   localparam int HI_W = NUM_W - QUO_W;

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [QUO_W-1:0]     sh_ff, sh_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;

   logic [DEN_W:0]       t1, t2, r1, r2;
   logic                 ge1, ge2;

   // Two restoring steps per cycle; quotient bits shift in as dividend bits shift out
   always_comb begin
      t1  = {rem_ff, sh_ff[QUO_W-1]};
      ge1 = t1 >= {1'b0, den_ff};
      r1  = ge1 ? (t1 - {1'b0, den_ff}) : t1;
      t2  = {r1[DEN_W-1:0], sh_ff[QUO_W-2]};
      ge2 = t2 >= {1'b0, den_ff};
      r2  = ge2 ? (t2 - {1'b0, den_ff}) : t2;
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      if (start) begin
         // A high part at or above the divisor means the quotient is far out of range
         rem_in = DEN_W'(num[NUM_W-1 -: HI_W]);
         ovf_in = DEN_W'(num[NUM_W-1 -: HI_W]) >= den;
         den_in = den;
         sh_in  = num[QUO_W-1:0];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = r2[DEN_W-1:0];
         sh_in  = {sh_ff[QUO_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      ovf_ff <= ovf_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign quo       = sh_ff;
   assign ovf       = ovf_ff;

endmodule

FILE: design/bli_ctrl.sv
module bli_ctrl import bli_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] start_cmd,
   input  div_stat_type     div_stat,
   input  logic             out_free,
   output ctl_type          ctl
);

   seq_state_type state_ff, state_in;
   logic          comp_ff, comp_in;
   cmd_type       cmd_ff, cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff  <= 1'b0;
         cmd_ff   <= CMD_ADD_FORCE;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         cmd_ff   <= cmd_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      comp_in  = comp_ff;
      cmd_in   = cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (cmd_type'(start_cmd))
                  CMD_EULER, CMD_PRE_HALF, CMD_POST_HALF: begin
                     state_in = ST_FRC_MUL;
                     comp_in  = 1'b0;
                     cmd_in   = cmd_type'(start_cmd);
                  end
                  default: state_in = ST_KE_SQX;
               endcase
            end
         end
         ST_FRC_MUL:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_VEL_UPD;
            end
         end
         ST_VEL_UPD: begin
            if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = ST_FRC_MUL;
            end else if (cmd_ff != CMD_POST_HALF) begin
               comp_in  = 1'b0;
               state_in = ST_VEL_MUL;
            end else begin
               state_in = ST_KE_SQX;
            end
         end
         ST_VEL_MUL: state_in = ST_POS_UPD;
         ST_POS_UPD: begin
            if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = ST_VEL_MUL;
            end else begin
               state_in = ST_KE_SQX;
            end
         end
         ST_KE_SQX: state_in = ST_KE_SQY;
         ST_KE_SQY: state_in = ST_KE_SUM;
         ST_KE_SUM: state_in = ST_KE_MLO;
         ST_KE_MLO: state_in = ST_KE_MHI;
         ST_KE_MHI: state_in = ST_KE_ACC;
         ST_KE_ACC: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl           = '0;
      ctl.mul_sel   = MS_FRC_DT;
      ctl.comp      = comp_ff;
      ctl.half      = cmd_ff != CMD_EULER;
      case (state_ff)
         ST_IDLE:      ctl.idle      = 1'b1;
         ST_FRC_MUL:   ctl.mul_sel   = MS_FRC_DT;
         ST_DIV_START: ctl.div_start = 1'b1;
         ST_VEL_UPD:   ctl.vel_upd   = 1'b1;
         ST_VEL_MUL:   ctl.mul_sel   = MS_VEL_DT;
         ST_POS_UPD:   ctl.pos_upd   = 1'b1;
         ST_KE_SQX:    ctl.mul_sel   = MS_VEL_SQX;
         ST_KE_SQY: begin
            ctl.mul_sel = MS_VEL_SQY;
            ctl.sq_load = 1'b1;
         end
         ST_KE_SUM:    ctl.sq_add    = 1'b1;
         ST_KE_MLO:    ctl.mul_sel   = MS_SQ_LO;
         ST_KE_MHI: begin
            ctl.mul_sel = MS_SQ_HI;
            ctl.ke_load = 1'b1;
         end
         ST_KE_ACC:    ctl.ke_add    = 1'b1;
         ST_DONE:      ctl.rsp_load  = out_free;
         default:      ctl.idle      = 1'b0;
      endcase
   end

endmodule

FILE: design/body_leapfrog_integrator.sv
// Sequence: a force, clear, load or unused command word applies on accept, then the energy is
//   computed; an Euler or pre-step first kicks then drifts each component, a post-step only kicks.
// Flow: one word at a time; the next command is taken the cycle after the result loads; the
//   work is paced by the shared 32x32 multiplier and the two-bit-per-cycle divider (used once
//   per velocity component), which holds the sequencer while it runs.
// Reset (synchronous, active high): state to zero, mass to 1.0, time step to 655; the
//   sequencer returns to idle and any pending result word is dropped.
module body_leapfrog_integrator import bli_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // command words
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [WORD_W-1:0] req_vec_x,
   input  logic signed [WORD_W-1:0] req_vec_y,
   // result words
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_pos_x,
   output logic signed [WORD_W-1:0] rsp_pos_y,
   output logic signed [WORD_W-1:0] rsp_vel_x,
   output logic signed [WORD_W-1:0] rsp_vel_y,
   output logic signed [WORD_W-1:0] rsp_force_x,
   output logic signed [WORD_W-1:0] rsp_force_y,
   output logic [KE_W-1:0]          rsp_kinetic_energy,
   output logic                     rsp_saturated,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [MASS_W-1:0]        csr_wdata
);

   localparam int DP_W = NUM_W - FRAC_W;
   localparam logic [MAG_W-1:0] STEP_LIM = MAG_W'(1) << WORD_W;

   // Magnitude of a signed word; the most negative value maps to 2^(WORD_W-1)
   function automatic logic [WORD_W-1:0] mag_of(input logic signed [WORD_W-1:0] v);
      logic [WORD_W-1:0] u;
      u = v;
      return v[WORD_W-1] ? (~u + 1'b1) : u;
   endfunction

   // base plus or minus a magnitude, saturated to the word range
   function automatic sat_type sat_add(input logic signed [WORD_W-1:0] base,
                                       input logic                     neg,
                                       input logic [MAG_W-1:0]         mag);
      logic signed [SUM_W-1:0] b_ext;
      logic signed [SUM_W-1:0] m_ext;
      logic signed [SUM_W-1:0] sum;
      sat_type                 r;
      b_ext = SUM_W'(base);
      m_ext = signed'({2'b00, mag});
      sum   = neg ? (b_ext - m_ext) : (b_ext + m_ext);
      if ((sum[SUM_W-1:WORD_W-1] == '0) || (sum[SUM_W-1:WORD_W-1] == '1)) begin
         r.clip  = 1'b0;
         r.value = sum[WORD_W-1:0];
      end else begin
         r.clip  = 1'b1;
         r.value = sum[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   ctl_type      ctl;
   div_stat_type div_stat;
   logic         req_accept;
   logic         out_free;

   // configuration
   logic [MASS_W-1:0] mass_ff, mass_in;
   logic [DT_W-1:0]   dt_ff, dt_in;

   // body state
   logic signed [WORD_W-1:0] pos_ff [2];
   logic signed [WORD_W-1:0] pos_in [2];
   logic signed [WORD_W-1:0] vel_ff [2];
   logic signed [WORD_W-1:0] vel_in [2];
   logic signed [WORD_W-1:0] frc_ff [2];
   logic signed [WORD_W-1:0] frc_in [2];
   logic                     clip_ff, clip_in;

   // shared multiplier and energy accumulation
   logic [WORD_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] sq_ff, sq_in;
   logic [ACC_W-1:0]  ke_ff, ke_in;

   // divider hookup
   logic [MASS_W-1:0] mass_eff;
   logic [DEN_W-1:0]  div_den;
   logic [QUO_W-1:0]  div_quo;
   logic              div_ovf;

   // step results
   logic [MAG_W-1:0]  dv, dp;
   logic [DP_W-1:0]   prod_sh;
   sat_type           add_x, add_y, kick_r, drift_r;
   logic              ke_cap;
   logic [KE_W-1:0]   ke_val;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_vel_x_ff, rsp_vel_y_ff;
   logic signed [WORD_W-1:0] rsp_force_x_ff, rsp_force_y_ff;
   logic [KE_W-1:0]          rsp_ke_ff;
   logic                     rsp_sat_ff;

   // ---------------------------------------------------------------------------------
   // Handshakes: take a command only while the sequencer idles; a finished word
   // may still wait in the result register meanwhile.
   // ---------------------------------------------------------------------------------
   assign req_stall  = !ctl.idle;
   assign req_accept = req_valid && ctl.idle;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   bli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .start_cmd (req_cmd),
      .div_stat  (div_stat),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   always_comb begin
      mass_in = mass_ff;
      dt_in   = dt_ff;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            CSR_BODY_MASS: mass_in = csr_wdata;
            CSR_TIME_STEP: dt_in   = csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Shared multiplier: operands picked by the sequencer, product registered.
   // ---------------------------------------------------------------------------------
   always_comb begin
      case (ctl.mul_sel)
         MS_FRC_DT: begin
            mul_a = mag_of(frc_ff[ctl.comp]);
            mul_b = WORD_W'(dt_ff);
         end
         MS_VEL_DT: begin
            mul_a = mag_of(vel_ff[ctl.comp]);
            mul_b = WORD_W'(dt_ff);
         end
         MS_VEL_SQX: begin
            mul_a = mag_of(vel_ff[0]);
            mul_b = mag_of(vel_ff[0]);
         end
         MS_VEL_SQY: begin
            mul_a = mag_of(vel_ff[1]);
            mul_b = mag_of(vel_ff[1]);
         end
         MS_SQ_LO: begin
            mul_a = sq_ff[WORD_W-1:0];
            mul_b = WORD_W'(mass_ff);
         end
         MS_SQ_HI: begin
            mul_a = sq_ff[PROD_W-1:WORD_W];
            mul_b = WORD_W'(mass_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Divide force times step by mass (doubled for half steps); zero mass counts as one LSB
   // ---------------------------------------------------------------------------------
   assign mass_eff = (mass_ff == '0) ? MASS_W'(1) : mass_ff;
   assign div_den  = ctl.half ? {mass_eff, 1'b0} : {1'b0, mass_eff};

   bli_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (prod_ff[NUM_W-1:0]),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // Clip each step to 2^WORD_W before adding: the sum saturates anyway, so this only
   // bounds the adder width.
   assign dv      = (div_ovf || (div_quo > QUO_W'(STEP_LIM))) ? STEP_LIM : div_quo[MAG_W-1:0];
   assign prod_sh = prod_ff[NUM_W-1:FRAC_W];
   assign dp      = (prod_sh > DP_W'(STEP_LIM)) ? STEP_LIM : prod_sh[MAG_W-1:0];

   assign add_x   = sat_add(frc_ff[0], req_vec_x[WORD_W-1], {1'b0, mag_of(req_vec_x)});
   assign add_y   = sat_add(frc_ff[1], req_vec_y[WORD_W-1], {1'b0, mag_of(req_vec_y)});
   // The velocity moves along the sign of the force, the position along the new velocity
   assign kick_r  = sat_add(vel_ff[ctl.comp], frc_ff[ctl.comp][WORD_W-1], dv);
   assign drift_r = sat_add(pos_ff[ctl.comp], vel_ff[ctl.comp][WORD_W-1], dp);

   // ---------------------------------------------------------------------------------
   // Body state: simple commands apply on accept, integration steps when sequenced
   // ---------------------------------------------------------------------------------
   always_comb begin
      pos_in  = pos_ff;
      vel_in  = vel_ff;
      frc_in  = frc_ff;
      clip_in = clip_ff;
      if (req_accept) begin
         clip_in = 1'b0;
         case (cmd_type'(req_cmd))
            CMD_ADD_FORCE: begin
               frc_in[0] = add_x.value;
               frc_in[1] = add_y.value;
               clip_in   = add_x.clip | add_y.clip;
            end
            CMD_CLR_FORCE: begin
               frc_in[0] = '0;
               frc_in[1] = '0;
            end
            CMD_LOAD_POS: begin
               pos_in[0] = req_vec_x;
               pos_in[1] = req_vec_y;
            end
            CMD_LOAD_VEL: begin
               vel_in[0] = req_vec_x;
               vel_in[1] = req_vec_y;
            end
            default: ;
         endcase
      end
      if (ctl.vel_upd) begin
         vel_in[ctl.comp] = kick_r.value;
         clip_in          = clip_ff | kick_r.clip;
      end
      if (ctl.pos_upd) begin
         pos_in[ctl.comp] = drift_r.value;
         clip_in          = clip_ff | drift_r.clip;
      end
   end

   // ---------------------------------------------------------------------------------
   // Kinetic energy: (vx^2 + vy^2) * m, split into two 32-bit halves times mass,
   // then shift out the fraction and the factor one half.
   // ---------------------------------------------------------------------------------
   always_comb begin
      sq_in = sq_ff;
      ke_in = ke_ff;
      if (ctl.sq_load) begin
         sq_in = prod_ff;
      end else if (ctl.sq_add) begin
         sq_in = sq_ff + prod_ff;
      end
      if (ctl.ke_load) begin
         ke_in = {MASS_W'(0), prod_ff};
      end else if (ctl.ke_add) begin
         ke_in = ke_ff + {prod_ff, WORD_W'(0)};
      end
   end

   assign ke_cap = ke_ff[ACC_W-1:KE_SHIFT+KE_W] != '0;
   assign ke_val = ke_cap ? '1 : ke_ff[KE_SHIFT+KE_W-1:KE_SHIFT];

   // ---------------------------------------------------------------------------------
   // Result register: load when the sequencer finishes, hold while stalled
   // ---------------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= MASS_RESET;
         dt_ff        <= DT_RESET;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         vel_ff[0]    <= '0;
         vel_ff[1]    <= '0;
         frc_ff[0]    <= '0;
         frc_ff[1]    <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mass_ff      <= mass_in;
         dt_ff        <= dt_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         frc_ff       <= frc_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      sq_ff   <= sq_in;
      ke_ff   <= ke_in;
      if (ctl.rsp_load) begin
         rsp_pos_x_ff   <= pos_ff[0];
         rsp_pos_y_ff   <= pos_ff[1];
         rsp_vel_x_ff   <= vel_ff[0];
         rsp_vel_y_ff   <= vel_ff[1];
         rsp_force_x_ff <= frc_ff[0];
         rsp_force_y_ff <= frc_ff[1];
         rsp_ke_ff      <= ke_val;
         rsp_sat_ff     <= clip_ff | ke_cap;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_pos_x_ff;
   assign rsp_pos_y          = rsp_pos_y_ff;
   assign rsp_vel_x          = rsp_vel_x_ff;
   assign rsp_vel_y          = rsp_vel_y_ff;
   assign rsp_force_x        = rsp_force_x_ff;
   assign rsp_force_y        = rsp_force_y_ff;
   assign rsp_kinetic_energy = rsp_ke_ff;
   assign rsp_saturated      = rsp_sat_ff;

`ifndef SYNTHESIS
   // No new command may slip in while a divide is still running
   a_div_busy_stall: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> req_stall)
      else $error("command accepted during divide");

   // Never overwrite a result word that is still stalled
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while stalled");

   // Zero mass gives zero energy
   a_zero_mass_ke: assert property (@(posedge clock) disable iff (reset)
      (ctl.rsp_load && (mass_ff == '0)) |=> (rsp_kinetic_energy == '0))
      else $error("nonzero energy with zero mass");
`endif

endmodule

FILE: sim/body_leapfrog_integrator_test.sv
`timescale 1ns / 100ps

import bli_pkg::*;

// One result word as the block presents it
typedef struct packed {
   logic [WORD_W-1:0] pos_x;
   logic [WORD_W-1:0] pos_y;
   logic [WORD_W-1:0] vel_x;
   logic [WORD_W-1:0] vel_y;
   logic [WORD_W-1:0] force_x;
   logic [WORD_W-1:0] force_y;
   logic [KE_W-1:0]   energy;
   logic              sat;
} body_result_type;

class body_scoreboard;
   logic signed [63:0] pos [2];
   logic signed [63:0] vel [2];
   logic signed [63:0] frc [2];
   logic [MASS_W-1:0]  mass;
   logic [DT_W-1:0]    dt;
   bit                 clipped;
   body_result_type    due_states [$];
   int                 errors;

   function new();
      mass   = MASS_RESET;
      dt     = DT_RESET;
      errors = 0;
      foreach (pos[k]) begin
         pos[k] = 0;
         vel[k] = 0;
         frc[k] = 0;
      end
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [MASS_W-1:0] data);
      if (idx == CSR_BODY_MASS) begin
         mass = data;
      end else begin
         dt = data[DT_W-1:0];
      end
   endfunction

   function int pending();
      return due_states.size();
   endfunction

   function logic signed [63:0] clamp_word(logic signed [63:0] v);
      logic signed [63:0] top;
      top = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
      if (v > top) begin
         clipped = 1'b1;
         return top;
      end
      if (v < -top - 64'sd1) begin
         clipped = 1'b1;
         return -top - 64'sd1;
      end
      return v;
   endfunction

   function logic [63:0] magnitude(logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // increment is capped at 2^WORD_W before the signed sum saturates
   function logic signed [63:0] step_by(logic signed [63:0] base, bit neg, logic [63:0] amount);
      logic signed [63:0] d;
      if (amount > (64'd1 << WORD_W)) amount = 64'd1 << WORD_W;
      d = amount;
      return clamp_word(neg ? base - d : base + d);
   endfunction

   // velocity gets force * dt / mass, halved for the leapfrog half steps
   function void kick(bit half);
      logic [63:0] den;
      logic [63:0] num;
      den = (mass != 0) ? 64'(mass) : 64'd1;
      if (half) den = den << 1;
      for (int k = 0; k < 2; k++) begin
         num    = magnitude(frc[k]) * 64'(dt);
         vel[k] = step_by(vel[k], frc[k] < 0, num / den);
      end
   endfunction

   // position gets the updated velocity times dt
   function void drift();
      for (int k = 0; k < 2; k++) begin
         pos[k] = step_by(pos[k], vel[k] < 0, (magnitude(vel[k]) * 64'(dt)) >> FRAC_W);
      end
   endfunction

   function void note_command(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] x,
                              logic signed [WORD_W-1:0] y);
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic [127:0]       energy;
      body_result_type    want;
      xs      = x;
      ys      = y;
      clipped = 1'b0;
      case (cmd)
         CMD_ADD_FORCE: begin
            frc[0] = clamp_word(frc[0] + xs);
            frc[1] = clamp_word(frc[1] + ys);
         end
         CMD_CLR_FORCE: begin
            frc[0] = 0;
            frc[1] = 0;
         end
         CMD_EULER: begin
            kick(1'b0);
            drift();
         end
         CMD_PRE_HALF: begin
            kick(1'b1);
            drift();
         end
         CMD_POST_HALF: begin
            kick(1'b1);
         end
         CMD_LOAD_POS: begin
            pos[0] = clamp_word(xs);
            pos[1] = clamp_word(ys);
         end
         CMD_LOAD_VEL: begin
            vel[0] = clamp_word(xs);
            vel[1] = clamp_word(ys);
         end
         default: ;
      endcase
      energy = 128'(magnitude(vel[0])) * 128'(magnitude(vel[0]))
             + 128'(magnitude(vel[1])) * 128'(magnitude(vel[1]));
      energy = (energy * 128'(mass)) >> KE_SHIFT;
      if (energy > ((128'd1 << KE_W) - 128'd1)) begin
         energy  = (128'd1 << KE_W) - 128'd1;
         clipped = 1'b1;
      end
      want.pos_x   = pos[0][WORD_W-1:0];
      want.pos_y   = pos[1][WORD_W-1:0];
      want.vel_x   = vel[0][WORD_W-1:0];
      want.vel_y   = vel[1][WORD_W-1:0];
      want.force_x = frc[0][WORD_W-1:0];
      want.force_y = frc[1][WORD_W-1:0];
      want.energy  = energy[KE_W-1:0];
      want.sat     = clipped;
      due_states = {due_states, want};
   endfunction

   function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         errors++;
      end
   endfunction

   function void check_state(body_result_type got);
      body_result_type want;
      if (due_states.size() == 0) begin
         $error("result word with no command outstanding");
         errors++;
         return;
      end
      want = due_states.pop_front();
      compare_field("pos_x", 64'(want.pos_x), 64'(got.pos_x));
      compare_field("pos_y", 64'(want.pos_y), 64'(got.pos_y));
      compare_field("vel_x", 64'(want.vel_x), 64'(got.vel_x));
      compare_field("vel_y", 64'(want.vel_y), 64'(got.vel_y));
      compare_field("force_x", 64'(want.force_x), 64'(got.force_x));
      compare_field("force_y", 64'(want.force_y), 64'(got.force_y));
      compare_field("kinetic_energy", 64'(want.energy), 64'(got.energy));
      compare_field("saturated", 64'(want.sat), 64'(got.sat));
   endfunction
endclass

module body_leapfrog_integrator_test;

   // there is no encoding for 7; the block must hand back the state untouched
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 270;
   localparam int HOLD_PHASE   = 4;     // receiver blocks for a long stretch here
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 80;    // longer than the slowest integrating word
   localparam int QUIET_LIMIT  = 5000;

   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd = CMD_CLR_FORCE;
   logic signed [WORD_W-1:0] req_vec_x = '0;
   logic signed [WORD_W-1:0] req_vec_y = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b1;
   logic signed [WORD_W-1:0] rsp_pos_x;
   logic signed [WORD_W-1:0] rsp_pos_y;
   logic signed [WORD_W-1:0] rsp_vel_x;
   logic signed [WORD_W-1:0] rsp_vel_y;
   logic signed [WORD_W-1:0] rsp_force_x;
   logic signed [WORD_W-1:0] rsp_force_y;
   logic [KE_W-1:0]          rsp_kinetic_energy;
   logic                     rsp_saturated;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_BODY_MASS;
   logic [MASS_W-1:0]        csr_wdata = '0;

   body_scoreboard board = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req      = 0;     // bumped by the stimulus to ask for a long hold
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int items_sent    = 0;

   always #5 clock = ~clock;

   body_leapfrog_integrator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_vec_x          (req_vec_x),
      .req_vec_y          (req_vec_y),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_vel_x          (rsp_vel_x),
      .rsp_vel_y          (rsp_vel_y),
      .rsp_force_x        (rsp_force_x),
      .rsp_force_y        (rsp_force_y),
      .rsp_kinetic_energy (rsp_kinetic_energy),
      .rsp_saturated      (rsp_saturated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Watch every channel at the edge; values seen here are the ones from before the edge.
   // Predict on each accepted command word, check each accepted result word, track
   // register writes, and give up if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) board.note_command(req_cmd, req_vec_x, req_vec_y);
         if (rsp_valid && !rsp_stall) begin
            board.check_state('{pos_x: rsp_pos_x, pos_y: rsp_pos_y,
                                vel_x: rsp_vel_x, vel_y: rsp_vel_y,
                                force_x: rsp_force_x, force_y: rsp_force_y,
                                energy: rsp_kinetic_energy, sat: rsp_saturated});
         end
      end
      if ((csr_valid && csr_ready) || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: stall at random, or hold off for a long stretch when asked so the
   // block backs up and has to stall its command input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one command word, idling first at the current rate; valid stays high after
   // acceptance so back-to-back words need no gap.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] x,
                            input logic [WORD_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_vec_x <= x;
      req_vec_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Write mass then time step back to back; drop valid only after the second.
   task automatic write_settings(input logic [MASS_W-1:0] mass, input logic [MASS_W-1:0] step);
      csr_valid <= 1'b1;
      csr_index <= CSR_BODY_MASS;
      csr_wdata <= mass;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_TIME_STEP;
      csr_wdata <= step;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Small physical values half the time, with the extremes and full-range noise mixed in
   function automatic logic [WORD_W-1:0] pick_vec();
      int small_val;
      small_val = int'($urandom_range(0, 4194304)) - 2097152;
      case ($urandom_range(9))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2, 3, 4: return $urandom;
         default: return small_val;
      endcase
   endfunction

   // Mostly well-formed integration sequences: clear, accumulate, then an Euler step or
   // a leapfrog pre/post pair; the rest is any command with random payload.
   task automatic random_step();
      if ($urandom_range(99) < 80) begin
         if ($urandom_range(9) == 0) send_word(CMD_LOAD_POS, pick_vec(), pick_vec());
         if ($urandom_range(9) == 0) send_word(CMD_LOAD_VEL, pick_vec(), pick_vec());
         send_word(CMD_CLR_FORCE, $urandom, $urandom);
         repeat ($urandom_range(1, 3)) send_word(CMD_ADD_FORCE, pick_vec(), pick_vec());
         if ($urandom_range(2) == 0) begin
            send_word(CMD_EULER, $urandom, $urandom);
         end else begin
            send_word(CMD_PRE_HALF, $urandom, $urandom);
            send_word(CMD_CLR_FORCE, $urandom, $urandom);
            repeat ($urandom_range(1, 2)) send_word(CMD_ADD_FORCE, pick_vec(), pick_vec());
            send_word(CMD_POST_HALF, $urandom, $urandom);
         end
      end else begin
         send_word(CMD_W'($urandom_range(0, 7)), $urandom, $urandom);
      end
   endtask

   initial begin
      int                ph;
      int                target;
      logic [MASS_W-1:0] mass_pick;
      logic [MASS_W-1:0] step_pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         // receiver-heavy idling, then sender-heavy, then none at all
         send_idle_pct = (ph < 2) ? 20 : ((ph < 4) ? 63 : 0);
         recv_idle_pct = (ph < 2) ? 63 : ((ph < 4) ? 20 : 0);

         if (ph > 0) begin
            // drain before touching the registers; step one edge first so the last
            // accepted command has been noted
            do @(posedge clock); while (board.pending() != 0);
            case (ph)
               1: begin
                  mass_pick = 32'd1;
                  step_pick = 32'h7FFF_FFFF;
               end
               2: begin
                  mass_pick = 32'hFFFF_FFFF;
                  step_pick = 32'd0;
               end
               3: begin
                  // zero mass: divide by one LSB, energy reads zero
                  mass_pick = 32'd0;
                  step_pick = 32'h0000_8000;
               end
               4: begin
                  mass_pick = $urandom_range(32'h0000_1000, 32'h0040_0000);
                  step_pick = $urandom_range(0, 32'h0001_0000);
               end
               default: begin
                  mass_pick = $urandom_range(1, 32'hFFFF_FFFF);
                  step_pick = $urandom_range(0, 32'h7FFF_FFFF);
               end
            endcase
            write_settings(mass_pick, step_pick);
         end

         if (ph == 0) begin
            // extremes of every field and every command at the reset settings
            send_word(CMD_LOAD_POS, WORD_MAX, WORD_MIN);
            send_word(CMD_LOAD_VEL, WORD_MAX, WORD_MIN);
            send_word(CMD_ADD_FORCE, WORD_MAX, WORD_MIN);
            send_word(CMD_ADD_FORCE, WORD_MAX, WORD_MIN);   // force sum saturates
            send_word(CMD_EULER, 32'd0, 32'd0);
            send_word(CMD_PRE_HALF, WORD_MAX, WORD_MAX);
            send_word(CMD_POST_HALF, WORD_MIN, WORD_MIN);
            send_word(CMD_CLR_FORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_word(CMD_UNUSED, WORD_MAX, WORD_MIN);
            send_word(CMD_LOAD_VEL, 32'd0, 32'd0);
            send_word(CMD_LOAD_POS, 32'd0, 32'd0);
            send_word(CMD_ADD_FORCE, 32'h0001_0000, 32'hFFFF_0000);
            send_word(CMD_PRE_HALF, 32'd0, 32'd0);
            send_word(CMD_CLR_FORCE, 32'd0, 32'd0);
            send_word(CMD_ADD_FORCE, 32'h0002_0000, 32'h0000_8000);
            send_word(CMD_POST_HALF, 32'd0, 32'd0);
            send_word(CMD_EULER, 32'd0, 32'd0);
            send_word(CMD_ADD_FORCE, WORD_MIN, WORD_MIN);
            send_word(CMD_ADD_FORCE, WORD_MIN, WORD_MIN);   // negative saturation
            send_word(CMD_EULER, 32'd0, 32'd0);
            send_word(CMD_LOAD_VEL, 32'hFFFF_FFFF, 32'h0000_0001);
            send_word(CMD_POST_HALF, 32'd0, 32'd0);
         end else begin
            // extreme speed: energy clips once the mass is large
            send_word(CMD_LOAD_VEL, WORD_MAX, WORD_MIN);
         end

         if (ph == HOLD_PHASE) hold_req++;

         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_step();
         req_valid <= 1'b0;
      end

      // wait out the outstanding results, then give the block time to show anything extra
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
